// ===== hdl/olir_pkg.sv =====
// Shared constants, codes and field layout of the ordered list core.
package olir_pkg;

  // List geometry
  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Field widths of the beats
  localparam int KIND_W   = 3;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int FIDX_W   = 6;
  localparam int COUNT_W  = 7;

  // Input beat layout (tdata: position, value)
  localparam int IN_POS_LO    = 0;
  localparam int IN_VAL_LO    = IN_POS_LO + POS_W;
  localparam int IN_USED_W    = IN_VAL_LO + DATA_WIDTH;
  localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Output beat layout (tdata: data, found, found_index, count, empty_res)
  localparam int OUT_DATA_LO  = 0;
  localparam int OUT_FOUND    = OUT_DATA_LO + DATA_WIDTH;
  localparam int OUT_FIDX_LO  = OUT_FOUND + 1;
  localparam int OUT_COUNT_LO = OUT_FIDX_LO + FIDX_W;
  localparam int OUT_EMPTY    = OUT_COUNT_LO + COUNT_W;
  localparam int OUT_USED_W   = OUT_EMPTY + 1;
  localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  // Operation codes
  localparam logic [KIND_W-1:0] OP_GET      = 3'd0;
  localparam logic [KIND_W-1:0] OP_SET      = 3'd1;
  localparam logic [KIND_W-1:0] OP_ADD      = 3'd2;
  localparam logic [KIND_W-1:0] OP_REMOVE   = 3'd3;
  localparam logic [KIND_W-1:0] OP_INDEX_OF = 3'd4;
  localparam logic [KIND_W-1:0] OP_CLEAR    = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ERR_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERR_FULL  = 2'd2;

endpackage

// ===== hdl/ordered_list_insert_remove_core.sv =====
// Ordered list of words with get, set, insert, remove, search and clear.
//
// Usage: each beat on the s_ stream carries one operation (kind on s_tuser,
// position and value on s_tdata) and yields exactly one result beat on the
// m_ stream (status on m_tuser; data, found flag, found index, entry count
// and empty flag on m_tdata). Entries live in one single-port-read,
// single-port-write RAM with a registered read.
// Get and set do one RAM read (set then writes); clear, index and full errors
// and unused codes touch no entry; add moves entries p..n-1 one slot up,
// remove moves the entries after p one slot down, and index_of reads from
// entry 0 to the first match or the end of the list.
// Insert, remove and search step through the RAM one entry per cycle. One
// beat is worked on at a time; s_tready is high whenever the engine is idle,
// even while a finished result still waits in the output register.
// Reset empties the list (entry count to zero) at once; no clearing pass.
// A stalled receiver holds the result in the output register; the next beat
// is then accepted and worked on, and waits to be delivered.
module ordered_list_insert_remove_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [6:0] position, [38:7] value, [39] zero
  input  logic [olir_pkg::IN_TDATA_W-1:0]      s_tdata,
  // [2:0] kind
  input  logic [olir_pkg::KIND_W-1:0]          s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [31:0] data, [32] found, [38:33] found_index, [45:39] count,
  // [46] empty_res, [47] zero
  output logic [olir_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // [1:0] status
  output logic [olir_pkg::STATUS_W-1:0]        m_tuser
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_START    = 3'd1;
  localparam logic [2:0] S_RMW      = 3'd2;
  localparam logic [2:0] S_SHIFT_UP = 3'd3;
  localparam logic [2:0] S_SHIFT_DN = 3'd4;
  localparam logic [2:0] S_SEARCH   = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]                          state;
  logic [olir_pkg::CNT_W-1:0]          cnt;
  logic [olir_pkg::CNT_W-1:0]          ptr;
  logic [olir_pkg::KIND_W-1:0]         kind;
  logic [olir_pkg::POS_W-1:0]          pos;
  logic [olir_pkg::DATA_WIDTH-1:0]     val;
  logic [olir_pkg::STATUS_W-1:0]       status;
  logic [olir_pkg::DATA_WIDTH-1:0]     data;
  logic                                found;
  logic [olir_pkg::FIDX_W-1:0]         fidx;
  logic                                rd_vld;
  logic [olir_pkg::IDX_W-1:0]          rd_addr_q;

  logic [olir_pkg::DATA_WIDTH-1:0]     mem [olir_pkg::CAPACITY];
  logic [olir_pkg::DATA_WIDTH-1:0]     mem_rdata;
  logic [olir_pkg::IDX_W-1:0]          mem_raddr;
  logic                                rd_issue;
  logic                                mem_we;
  logic [olir_pkg::IDX_W-1:0]          mem_waddr;
  logic [olir_pkg::DATA_WIDTH-1:0]     mem_wdata;

  logic [olir_pkg::IDX_W-1:0]          pos_idx;
  logic [olir_pkg::CNT_W-1:0]          ptr_dec;
  logic                                hit;
  logic                                idx_bad;
  logic                                out_load;

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  // Decode helpers and RAM port control
  always_comb begin
    pos_idx   = pos[olir_pkg::IDX_W-1:0];
    ptr_dec   = ptr - olir_pkg::CNT_W'(1);
    hit       = rd_vld && (mem_rdata == val);
    idx_bad   = (olir_pkg::CNT_W'(pos) >= cnt);
    rd_issue  = 1'b0;
    mem_raddr = ptr[olir_pkg::IDX_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = rd_addr_q;
    mem_wdata = mem_rdata;
    unique case (state)
      S_START: begin
        if ((kind == olir_pkg::OP_GET || kind == olir_pkg::OP_SET ||
             kind == olir_pkg::OP_REMOVE) && !idx_bad) begin
          rd_issue  = 1'b1;
          mem_raddr = pos_idx;
        end
      end
      S_RMW: begin
        if (kind == olir_pkg::OP_SET) begin
          mem_we    = 1'b1;
          mem_waddr = pos_idx;
          mem_wdata = val;
        end
      end
      S_SHIFT_UP: begin
        // move the entry read last cycle one slot up, then drop in the value
        if (rd_vld) begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr_q + olir_pkg::IDX_W'(1);
        end else if (olir_pkg::CNT_W'(pos) == ptr) begin
          mem_we    = 1'b1;
          mem_waddr = pos_idx;
          mem_wdata = val;
        end
        if (ptr > olir_pkg::CNT_W'(pos)) begin
          rd_issue  = 1'b1;
          mem_raddr = ptr_dec[olir_pkg::IDX_W-1:0];
        end
      end
      S_SHIFT_DN: begin
        // move each later entry one slot down; the first read is the old value
        if (rd_vld && rd_addr_q != pos_idx) begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr_q - olir_pkg::IDX_W'(1);
        end
        if (ptr < cnt) begin
          rd_issue = 1'b1;
        end
      end
      S_SEARCH: begin
        if (!hit && ptr < cnt) begin
          rd_issue = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Entry RAM with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // Track the read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_issue;
    end
    rd_addr_q <= mem_raddr;
  end

  // Operation sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind   <= s_tuser;
            pos    <= s_tdata[olir_pkg::IN_POS_LO +: olir_pkg::POS_W];
            val    <= s_tdata[olir_pkg::IN_VAL_LO +: olir_pkg::DATA_WIDTH];
            status <= olir_pkg::ST_OK;
            data   <= '0;
            found  <= 1'b0;
            fidx   <= '0;
            state  <= S_START;
          end
        end
        S_START: begin
          unique case (kind)
            olir_pkg::OP_GET, olir_pkg::OP_SET: begin
              if (idx_bad) begin
                status <= olir_pkg::ST_ERR_INDEX;
                state  <= S_DONE;
              end else begin
                state <= S_RMW;
              end
            end
            olir_pkg::OP_REMOVE: begin
              if (idx_bad) begin
                status <= olir_pkg::ST_ERR_INDEX;
                state  <= S_DONE;
              end else begin
                ptr   <= olir_pkg::CNT_W'(pos) + olir_pkg::CNT_W'(1);
                state <= S_SHIFT_DN;
              end
            end
            olir_pkg::OP_ADD: begin
              if (olir_pkg::CNT_W'(pos) > cnt) begin
                status <= olir_pkg::ST_ERR_INDEX;
                state  <= S_DONE;
              end else if (cnt == olir_pkg::CNT_W'(olir_pkg::CAPACITY)) begin
                status <= olir_pkg::ST_ERR_FULL;
                state  <= S_DONE;
              end else begin
                ptr   <= cnt;
                state <= S_SHIFT_UP;
              end
            end
            olir_pkg::OP_INDEX_OF: begin
              ptr   <= '0;
              state <= S_SEARCH;
            end
            olir_pkg::OP_CLEAR: begin
              cnt   <= '0;
              state <= S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_RMW: begin
          data  <= mem_rdata;
          state <= S_DONE;
        end
        S_SHIFT_UP: begin
          if (ptr > olir_pkg::CNT_W'(pos)) begin
            ptr <= ptr_dec;
          end else if (!rd_vld) begin
            cnt   <= cnt + olir_pkg::CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_SHIFT_DN: begin
          if (rd_vld && rd_addr_q == pos_idx) begin
            data <= mem_rdata;
          end
          if (ptr < cnt) begin
            ptr <= ptr + olir_pkg::CNT_W'(1);
          end else if (!rd_vld) begin
            cnt   <= cnt - olir_pkg::CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_SEARCH: begin
          if (hit) begin
            found <= 1'b1;
            fidx  <= olir_pkg::FIDX_W'(rd_addr_q);
            state <= S_DONE;
          end else if (ptr < cnt) begin
            ptr <= ptr + olir_pkg::CNT_W'(1);
          end else if (!rd_vld) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= status;
      m_tdata <= olir_pkg::OUT_TDATA_W'({(cnt == '0), olir_pkg::COUNT_W'(cnt),
                                         fidx, found, data});
    end
  end

endmodule

// ===== hdl/olir_checker.sv =====
// Port-level checker for the ordered list core, bound to the core module.
module olir_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [olir_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input logic [olir_pkg::STATUS_W-1:0]      m_tuser
);

  logic [olir_pkg::COUNT_W-1:0] res_count;
  logic [olir_pkg::FIDX_W-1:0]  res_fidx;
  logic                         res_found;
  logic                         res_empty;
  logic [olir_pkg::DATA_WIDTH-1:0] res_data;

  assign res_count = m_tdata[olir_pkg::OUT_COUNT_LO +: olir_pkg::COUNT_W];
  assign res_fidx  = m_tdata[olir_pkg::OUT_FIDX_LO +: olir_pkg::FIDX_W];
  assign res_found = m_tdata[olir_pkg::OUT_FOUND];
  assign res_empty = m_tdata[olir_pkg::OUT_EMPTY];
  assign res_data  = m_tdata[olir_pkg::OUT_DATA_LO +: olir_pkg::DATA_WIDTH];

  // A stalled result beat holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // Reported count never exceeds the capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res_count <= olir_pkg::COUNT_W'(olir_pkg::CAPACITY))
    else $error("count beyond capacity");

  // Empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res_empty == (res_count == '0))
    else $error("empty flag disagrees with count");

  // A failed operation returns no data and no match
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != olir_pkg::ST_OK |-> res_data == '0 && !res_found)
    else $error("error result carries data");

  // Without a match the found index is zero and lies inside the list otherwise
  a_fidx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!res_found && res_fidx == '0) ||
                 (res_found && olir_pkg::COUNT_W'(res_fidx) < res_count))
    else $error("found index inconsistent");

endmodule

bind ordered_list_insert_remove_core olir_checker u_olir_checker (.*);

// ===== test/tb.sv =====
// Self-checking testbench for the ordered list core: list predictor, scoreboard and stimulus.
package list_check_pkg;
  import olir_pkg::*;

  // One result beat, field by field
  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [DATA_WIDTH-1:0] data;
    logic                  found;
    logic [FIDX_W-1:0]     found_index;
    logic [COUNT_W-1:0]    count;
    logic                  empty_res;
  } list_result_t;

  class list_scoreboard;
    logic [DATA_WIDTH-1:0] entries [CAPACITY];
    int unsigned           count;
    list_result_t          pending_results [$];
    int unsigned           errors;
    int unsigned           checked;

    function new();
      count   = 0;
      errors  = 0;
      checked = 0;
      foreach (entries[i]) entries[i] = '0;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    // Apply one accepted operation to the shadow list and queue its result
    function void note_op(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                          logic [DATA_WIDTH-1:0] val);
      list_result_t r;
      int i;
      r = '0;
      case (kind)
        OP_GET: begin
          if (pos >= count) r.status = ST_ERR_INDEX;
          else r.data = entries[pos];
        end
        OP_SET: begin
          if (pos >= count) begin
            r.status = ST_ERR_INDEX;
          end else begin
            r.data = entries[pos];
            entries[pos] = val;
          end
        end
        OP_ADD: begin
          // position is checked before capacity
          if (pos > count) begin
            r.status = ST_ERR_INDEX;
          end else if (count >= CAPACITY) begin
            r.status = ST_ERR_FULL;
          end else begin
            for (i = count; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = val;
            count++;
          end
        end
        OP_REMOVE: begin
          if (pos >= count) begin
            r.status = ST_ERR_INDEX;
          end else begin
            r.data = entries[pos];
            for (i = pos + 1; i < count; i++) entries[i-1] = entries[i];
            count--;
            entries[count] = '0;
          end
        end
        OP_INDEX_OF: begin
          // first match wins
          for (i = 0; i < count; i++) begin
            if (entries[i] == val) begin
              r.found       = 1'b1;
              r.found_index = FIDX_W'(i);
              break;
            end
          end
        end
        OP_CLEAR: begin
          foreach (entries[j]) entries[j] = '0;
          count = 0;
        end
        default: ;
      endcase
      r.count     = COUNT_W'(count);
      r.empty_res = (count == 0);
      pending_results.push_back(r);
    endfunction

    function void check_field(string name, logic [DATA_WIDTH-1:0] want,
                              logic [DATA_WIDTH-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // Compare one delivered result beat with the oldest expectation
    function void check_result(list_result_t got);
      list_result_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with no operation outstanding");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      check_field("status", DATA_WIDTH'(want.status), DATA_WIDTH'(got.status));
      check_field("data", want.data, got.data);
      check_field("found", DATA_WIDTH'(want.found), DATA_WIDTH'(got.found));
      check_field("found_index", DATA_WIDTH'(want.found_index),
                  DATA_WIDTH'(got.found_index));
      check_field("count", DATA_WIDTH'(want.count), DATA_WIDTH'(got.count));
      check_field("empty_res", DATA_WIDTH'(want.empty_res),
                  DATA_WIDTH'(got.empty_res));
    endfunction
  endclass
endpackage

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import olir_pkg::*;
  import list_check_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AFTER   = 300;

  // Kind codes the block treats as no operation
  localparam logic [KIND_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] OP_SPARE_B = 3'd7;

  typedef enum int {MIX_GROW, MIX_BALANCED, MIX_FILL, MIX_SHRINK} mix_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [KIND_W-1:0]      s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]    m_tuser;

  list_scoreboard sb = new();

  ordered_list_insert_remove_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // Word for set/add/index_of: small values repeat so searches hit duplicates
  function automatic logic [DATA_WIDTH-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return $urandom_range(0, 7);
    if (r == 2) return $urandom_range(0, 1) ? '1 : 32'h8000_0000;
    return $urandom;
  endfunction

  // Offer one operation beat, hold it until accepted, then note it
  task automatic send(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                      input logic [DATA_WIDTH-1:0] val, input int gap);
    logic [IN_TDATA_W-1:0] beat;
    beat = '0;
    beat[IN_POS_LO +: POS_W]      = pos;
    beat[IN_VAL_LO +: DATA_WIDTH] = val;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= beat;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    sb.note_op(kind, pos, val);
  endtask

  task automatic wait_drained();
    while (sb.outstanding() > 0) @(posedge clk);
  endtask

  // Draw one operation, weighted by the current mix and the list fill
  task automatic pick_op(input mix_t mode, output logic [KIND_W-1:0] kind,
                         output logic [POS_W-1:0] pos, output logic [DATA_WIDTH-1:0] val);
    int n, r, add_w, rem_w;
    n = sb.count;
    case (mode)
      MIX_GROW:   begin add_w = 50; rem_w = 15; end
      MIX_FILL:   begin add_w = 90; rem_w = 2;  end
      MIX_SHRINK: begin add_w = 15; rem_w = 50; end
      default:    begin add_w = 30; rem_w = 30; end
    endcase
    r = $urandom_range(0, 99);
    if (r < add_w) kind = OP_ADD;
    else if (r < add_w + rem_w) kind = OP_REMOVE;
    else begin
      r = $urandom_range(0, 99);
      if (r < 30) kind = OP_GET;
      else if (r < 58) kind = OP_SET;
      else if (r < 92) kind = OP_INDEX_OF;
      else if (r < 96) kind = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
      else kind = OP_CLEAR;
    end
    // position: mostly legal with the ends favored, sometimes anything
    r = $urandom_range(0, 99);
    if (r < 12 || kind == OP_SPARE_A || kind == OP_SPARE_B)
      pos = POS_W'($urandom_range(0, 127));
    else if (kind == OP_ADD)
      pos = POS_W'((r < 22) ? 0 : (r < 34) ? n : $urandom_range(0, n));
    else if (n == 0) pos = '0;
    else pos = POS_W'((r < 22) ? 0 : (r < 34) ? n - 1 : $urandom_range(0, n - 1));
    // search for a stored word most of the time
    if (kind == OP_INDEX_OF && n > 0 && $urandom_range(0, 9) < 6)
      val = sb.entries[$urandom_range(0, n - 1)];
    else
      val = pick_word();
  endtask

  // Capture result beats; the handshake completes at the next rising edge
  always @(negedge clk) begin : result_monitor
    list_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status      = m_tuser;
      got.data        = m_tdata[OUT_DATA_LO +: DATA_WIDTH];
      got.found       = m_tdata[OUT_FOUND];
      got.found_index = m_tdata[OUT_FIDX_LO +: FIDX_W];
      got.count       = m_tdata[OUT_COUNT_LO +: COUNT_W];
      got.empty_res   = m_tdata[OUT_EMPTY];
      sb.check_result(got);
    end
  end

  // Result sink: random back-pressure, free-running stretches, one long hold
  initial begin : result_sink
    bit level;
    int left;
    bit held;
    level = 1'b0;
    left  = 0;
    held  = 1'b0;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (left == 0) begin
        if (!held && sb.checked >= HOLD_AFTER) begin
          level = 1'b0;
          left  = LONG_HOLD;
          held  = 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
          level = 1'b1;
          left  = $urandom_range(50, 150);
        end else if (level) begin
          level = 1'b0;
          left  = idle_len() + 1;
        end else begin
          level = 1'b1;
          left  = $urandom_range(1, 8);
        end
      end
      m_tready <= level;
      left--;
      @(posedge clk);
    end
  end

  // Run guard
  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Operation stream
  initial begin : op_source
    int   left_items;
    int   phase;
    int   len;
    bit   burst;
    mix_t mode;
    logic [KIND_W-1:0]     k;
    logic [POS_W-1:0]      p;
    logic [DATA_WIDTH-1:0] v;

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_GET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // errors on an empty list
    send(OP_GET,    7'd0, 32'h0, idle_len());
    send(OP_REMOVE, 7'd0, 32'h0, idle_len());
    send(OP_ADD,    7'd1, 32'h0, idle_len());
    // insert at front, back and middle, extreme words
    send(OP_ADD,    7'd0, 32'h0000_0000, idle_len());
    send(OP_ADD,    7'd1, 32'hFFFF_FFFF, idle_len());
    send(OP_ADD,    7'd0, 32'hA5A5_A5A5, idle_len());
    send(OP_ADD,    7'd1, 32'h5A5A_5A5A, idle_len());
    send(OP_ADD,    7'd4, 32'h0000_0000, idle_len());
    // reads at both ends and just past the end
    send(OP_GET,    7'd0, 32'h0, idle_len());
    send(OP_GET,    7'd4, 32'h0, idle_len());
    send(OP_GET,    7'd5, 32'h0, idle_len());
    send(OP_SET,    7'd2, 32'h1234_5678, idle_len());
    send(OP_SET,    7'd127, 32'hFFFF_FFFF, idle_len());
    // search: last word, a middle word, missing word
    send(OP_INDEX_OF, 7'd0, 32'h0000_0000, idle_len());
    send(OP_INDEX_OF, 7'd0, 32'hFFFF_FFFF, idle_len());
    send(OP_INDEX_OF, 7'd0, 32'hDEAD_BEEF, idle_len());
    // remove in the middle and at the top, then out of range
    send(OP_REMOVE, 7'd1, 32'h0, idle_len());
    send(OP_REMOVE, 7'd3, 32'h0, idle_len());
    send(OP_REMOVE, 7'd64, 32'h0, idle_len());
    // unused kind codes
    send(OP_SPARE_A, 7'd127, 32'hFFFF_FFFF, idle_len());
    send(OP_SPARE_B, 7'd0, 32'h0, idle_len());
    send(OP_GET,    7'd64, 32'h0, idle_len());
    send(OP_CLEAR,  7'd0, 32'h0, idle_len());
    send(OP_INDEX_OF, 7'd0, 32'h0000_0000, idle_len());
    send(OP_ADD,    7'd0, 32'h0000_0007, idle_len());

    // pause until the list core has answered everything
    s_tvalid <= 1'b0;
    wait_drained();

    // random phases: grow, mixed, fill to capacity, shrink
    left_items = RANDOM_ITEMS;
    phase = 0;
    while (left_items > 0) begin
      mode  = mix_t'(phase % 4);
      len   = (mode == MIX_FILL) ? 110 : $urandom_range(50, 100);
      burst = ($urandom_range(0, 3) == 0);
      if (phase == 5) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end
      for (int j = 0; j < len && left_items > 0; j++) begin
        pick_op(mode, k, p, v);
        send(k, p, v, burst ? 0 : idle_len());
        left_items--;
      end
      phase++;
    end

    // drain, then let the core settle
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
